### sv/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and codes for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 8;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_ASC  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INS_DESC = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXT_HEAD = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EXT_TAIL = 3'd5;
  localparam logic [KIND_W-1:0] KIND_EXT_KEY  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SEARCH   = 3'd7;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } rec_t;

endpackage

### sv/bole_store.sv
// ----------------------------------------------------------------------------
// bole_store
// Record memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module bole_store #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [IW-1:0]  waddr,
  input  bole_pkg::rec_t wdata,
  input  logic [IW-1:0]  raddr,
  output bole_pkg::rec_t rdata
);

  bole_pkg::rec_t mem [DEPTH];
  bole_pkg::rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/bounded_ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Ordered list of key/value records held in a memory, served by a sequencer
// that scans for a position or key and, where needed, shifts records one per cycle.
//
//   channel  ports                                   handshake
//   input    in_kind, in_key, in_value               start & !busy
//   result   out_status, out_key, out_value,         out_valid, one cycle
//            out_entry_count
//
// Within a transaction, a pipelined scan, where needed, reads one record per
// cycle through the single memory read port, then a shift, where needed,
// moves one record per cycle through the same port and the write port.
// Reset clears the record count and the control state only; record storage needs no clearing.
// The receiver cannot stall; busy is low again in the cycle of the result strobe.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bole_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [bole_pkg::KEY_W-1:0]  in_key,
  input  logic [bole_pkg::VAL_W-1:0]         in_value,
  output logic                               out_valid,
  output logic [bole_pkg::STAT_W-1:0]        out_status,
  output logic signed [bole_pkg::KEY_W-1:0]  out_key,
  output logic [bole_pkg::VAL_W-1:0]         out_value,
  output logic [$clog2(CAPACITY+1)-1:0]      out_entry_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_PUT} state_t;

  state_t                            state_r, state_nxt;
  logic [CW-1:0]                     occ_r, occ_nxt;
  logic [bole_pkg::KIND_W-1:0]       kind_r, kind_nxt;
  logic signed [bole_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [bole_pkg::VAL_W-1:0]        val_r, val_nxt;
  logic [IW-1:0]                     pos_r, pos_nxt;
  logic [IW-1:0]                     rp_r, rp_nxt;
  logic [IW-1:0]                     lim_r, lim_nxt;
  logic                              up_r, up_nxt;
  logic                              issuing_r, issuing_nxt;
  logic                              rd_ok_r, rd_ok_nxt;
  logic [IW-1:0]                     rd_idx_r, rd_idx_nxt;
  logic [bole_pkg::STAT_W-1:0]       res_status_r, res_status_nxt;
  bole_pkg::rec_t                    res_r, res_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [bole_pkg::STAT_W-1:0]       out_status_r, out_status_nxt;
  bole_pkg::rec_t                    out_rec_r, out_rec_nxt;
  logic [CW-1:0]                     out_count_r, out_count_nxt;

  logic                              we;
  logic [IW-1:0]                     waddr;
  bole_pkg::rec_t                    wdata;
  bole_pkg::rec_t                    rdata;

  logic                              go_scan, go_open, go_close, go_finish;
  logic [CW-1:0]                     pos_sel;
  logic [CW-1:0]                     scan_start, scan_lim;
  logic [CW-1:0]                     occ_m1;
  logic                              hit;
  logic                              is_ins;

  bole_store #(
    .DEPTH(CAPACITY),
    .IW   (IW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rp_r),
    .rdata(rdata)
  );

  assign occ_m1 = occ_r - CW'(1);
  assign is_ins = (kind_r == bole_pkg::KIND_INS_HEAD) || (kind_r == bole_pkg::KIND_INS_TAIL) ||
                  (kind_r == bole_pkg::KIND_INS_ASC) || (kind_r == bole_pkg::KIND_INS_DESC);

  always_comb begin
    case (kind_r)
      bole_pkg::KIND_INS_ASC:  hit = !($signed(rdata.key) < key_r);
      bole_pkg::KIND_INS_DESC: hit = !(key_r < $signed(rdata.key));
      bole_pkg::KIND_EXT_HEAD,
      bole_pkg::KIND_EXT_TAIL: hit = 1'b1;
      default:                 hit = (rdata.key == key_r);
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = '{key: key_r, value: val_r};
    if (state_r == S_SHIFT && rd_ok_r) begin
      we    = 1'b1;
      waddr = up_r ? (rd_idx_r - IW'(1)) : (rd_idx_r + IW'(1));
      wdata = rdata;
    end else if (state_r == S_PUT) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    lim_nxt        = lim_r;
    up_nxt         = up_r;
    res_status_nxt = res_status_r;
    res_nxt        = res_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    issuing_nxt    = issuing_r;
    rd_ok_nxt      = issuing_r;
    rd_idx_nxt     = rp_r;
    rp_nxt         = rp_r;
    if (issuing_r) begin
      rp_nxt = up_r ? (rp_r + IW'(1)) : (rp_r - IW'(1));
      if (rp_r == lim_r) begin
        issuing_nxt = 1'b0;
      end
    end
    go_scan    = 1'b0;
    go_open    = 1'b0;
    go_close   = 1'b0;
    go_finish  = 1'b0;
    pos_sel    = '0;
    scan_start = '0;
    scan_lim   = occ_m1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt       = in_kind;
          key_nxt        = in_key;
          val_nxt        = in_value;
          res_status_nxt = bole_pkg::STAT_OK;
          res_nxt        = '0;
          case (in_kind)
            bole_pkg::KIND_INS_HEAD, bole_pkg::KIND_INS_TAIL,
            bole_pkg::KIND_INS_ASC, bole_pkg::KIND_INS_DESC: begin
              if (occ_r == CW'(CAPACITY)) begin
                res_status_nxt = bole_pkg::STAT_FULL;
                go_finish      = 1'b1;
              end else if (in_kind == bole_pkg::KIND_INS_TAIL || occ_r == '0) begin
                pos_sel = occ_r;
                go_open = 1'b1;
              end else if (in_kind == bole_pkg::KIND_INS_HEAD) begin
                pos_sel = '0;
                go_open = 1'b1;
              end else begin
                go_scan = 1'b1;
              end
            end
            bole_pkg::KIND_EXT_HEAD, bole_pkg::KIND_EXT_TAIL, bole_pkg::KIND_EXT_KEY: begin
              if (occ_r == '0) begin
                res_status_nxt = bole_pkg::STAT_EMPTY;
                go_finish      = 1'b1;
              end else begin
                go_scan = 1'b1;
                if (in_kind == bole_pkg::KIND_EXT_HEAD) begin
                  scan_lim = '0;
                end else if (in_kind == bole_pkg::KIND_EXT_TAIL) begin
                  scan_start = occ_m1;
                end
              end
            end
            default: begin
              if (occ_r == '0) begin
                res_status_nxt = bole_pkg::STAT_NOT_FOUND;
                go_finish      = 1'b1;
              end else begin
                go_scan = 1'b1;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_ok_r) begin
          if (hit) begin
            pos_sel = CW'(rd_idx_r);
            if (kind_r == bole_pkg::KIND_SEARCH) begin
              res_nxt   = rdata;
              go_finish = 1'b1;
            end else if (!is_ins) begin
              res_nxt  = rdata;
              go_close = 1'b1;
            end else begin
              go_open = 1'b1;
            end
          end else if (rd_idx_r == lim_r) begin
            if (is_ins) begin
              pos_sel = occ_r;
              go_open = 1'b1;
            end else begin
              res_status_nxt = bole_pkg::STAT_NOT_FOUND;
              go_finish      = 1'b1;
            end
          end
        end
      end
      S_SHIFT: begin
        if (rd_ok_r && rd_idx_r == lim_r) begin
          if (is_ins) begin
            state_nxt   = S_PUT;
            issuing_nxt = 1'b0;
            rd_ok_nxt   = 1'b0;
          end else begin
            occ_nxt   = occ_m1;
            go_finish = 1'b1;
          end
        end
      end
      S_PUT: begin
        occ_nxt   = occ_r + CW'(1);
        go_finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_scan) begin
      state_nxt   = S_SCAN;
      rp_nxt      = scan_start[IW-1:0];
      lim_nxt     = scan_lim[IW-1:0];
      up_nxt      = 1'b1;
      issuing_nxt = 1'b1;
      rd_ok_nxt   = 1'b0;
    end
    if (go_open) begin
      pos_nxt     = pos_sel[IW-1:0];
      rd_ok_nxt   = 1'b0;
      if (pos_sel == occ_r) begin
        state_nxt   = S_PUT;
        issuing_nxt = 1'b0;
      end else begin
        state_nxt   = S_SHIFT;
        rp_nxt      = occ_m1[IW-1:0];
        lim_nxt     = pos_sel[IW-1:0];
        up_nxt      = 1'b0;
        issuing_nxt = 1'b1;
      end
    end
    if (go_close) begin
      rd_ok_nxt = 1'b0;
      if (pos_sel == occ_m1) begin
        occ_nxt   = occ_m1;
        go_finish = 1'b1;
      end else begin
        state_nxt   = S_SHIFT;
        rp_nxt      = pos_sel[IW-1:0] + IW'(1);
        lim_nxt     = occ_m1[IW-1:0];
        up_nxt      = 1'b1;
        issuing_nxt = 1'b1;
      end
    end
    if (go_finish) begin
      state_nxt      = S_IDLE;
      issuing_nxt    = 1'b0;
      rd_ok_nxt      = 1'b0;
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_nxt;
      out_rec_nxt    = res_nxt;
      out_count_nxt  = occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      issuing_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      issuing_r   <= issuing_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    rp_r         <= rp_nxt;
    lim_r        <= lim_nxt;
    up_r         <= up_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key         = out_rec_r.key;
  assign out_value       = out_rec_r.value;
  assign out_entry_count = out_count_r;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the bounded ordered list engine. A scoreboard
// keeps its own copy of the ordered list, predicts the result of every
// accepted transaction and compares each result strobe field by field.
// Stimulus is a directed opening followed by random traffic that swings the
// list between empty and full under three sender idling patterns.
// ----------------------------------------------------------------------------
localparam int LIST_DEPTH = 16;
localparam int COUNT_W = $clog2(LIST_DEPTH + 1);

typedef struct {
  logic [bole_pkg::STAT_W-1:0]        status;
  logic signed [bole_pkg::KEY_W-1:0]  key;
  logic [bole_pkg::VAL_W-1:0]         value;
  logic [COUNT_W-1:0]                 count;
} list_result_t;

class list_scoreboard;
  logic signed [bole_pkg::KEY_W-1:0] keys [LIST_DEPTH];
  logic [bole_pkg::VAL_W-1:0]        values [LIST_DEPTH];
  int                                held;
  list_result_t                      pending_results[$];
  int                                errors;
  int                                checked;
  int                                status_seen[4];
  int                                peak;

  function int locate(logic signed [bole_pkg::KEY_W-1:0] key);
    int pos;
    pos = 0;
    while (pos < held && keys[pos] != key) pos++;
    return pos;
  endfunction

  function logic signed [bole_pkg::KEY_W-1:0] held_key();
    return keys[$urandom_range(held - 1)];
  endfunction

  function void note_command(logic [bole_pkg::KIND_W-1:0] kind,
                             logic signed [bole_pkg::KEY_W-1:0] key,
                             logic [bole_pkg::VAL_W-1:0] value);
    list_result_t r;
    int pos;
    r.status = bole_pkg::STAT_OK;
    r.key = '0;
    r.value = '0;
    pos = 0;
    case (kind)
      bole_pkg::KIND_INS_HEAD, bole_pkg::KIND_INS_TAIL,
      bole_pkg::KIND_INS_ASC, bole_pkg::KIND_INS_DESC: begin
        if (held >= LIST_DEPTH) begin
          r.status = bole_pkg::STAT_FULL;
        end else begin
          if (kind == bole_pkg::KIND_INS_TAIL) begin
            pos = held;
          end else if (kind == bole_pkg::KIND_INS_ASC) begin
            while (pos < held && keys[pos] < key) pos++;
          end else if (kind == bole_pkg::KIND_INS_DESC) begin
            while (pos < held && keys[pos] > key) pos++;
          end
          for (int i = held; i > pos; i--) begin
            keys[i] = keys[i-1];
            values[i] = values[i-1];
          end
          keys[pos] = key;
          values[pos] = value;
          held++;
        end
      end
      bole_pkg::KIND_SEARCH: begin
        pos = locate(key);
        if (pos < held) begin
          r.key = keys[pos];
          r.value = values[pos];
        end else begin
          r.status = bole_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = bole_pkg::STAT_EMPTY;
        end else begin
          if (kind == bole_pkg::KIND_EXT_HEAD) pos = 0;
          else if (kind == bole_pkg::KIND_EXT_TAIL) pos = held - 1;
          else pos = locate(key);
          if (pos < held) begin
            r.key = keys[pos];
            r.value = values[pos];
            for (int i = pos; i + 1 < held; i++) begin
              keys[i] = keys[i+1];
              values[i] = values[i+1];
            end
            held--;
          end else begin
            r.status = bole_pkg::STAT_NOT_FOUND;
          end
        end
      end
    endcase
    if (held > peak) peak = held;
    r.count = COUNT_W'(held);
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [bole_pkg::STAT_W-1:0] status,
                             logic signed [bole_pkg::KEY_W-1:0] key,
                             logic [bole_pkg::VAL_W-1:0] value,
                             logic [COUNT_W-1:0] count);
    list_result_t e;
    if (pending_results.size() == 0) begin
      $error("result with no transaction waiting: status %0d key %0d value %0d count %0d",
             status, key, value, count);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    checked++;
    status_seen[e.status]++;
    if (status !== e.status) begin
      $error("out_status mismatch: expected %0d, actual %0d", e.status, status);
      errors++;
    end
    if (key !== e.key) begin
      $error("out_key mismatch: expected %0d, actual %0d", e.key, key);
      errors++;
    end
    if (value !== e.value) begin
      $error("out_value mismatch: expected %0d, actual %0d", e.value, value);
      errors++;
    end
    if (count !== e.count) begin
      $error("out_entry_count mismatch: expected %0d, actual %0d", e.count, count);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [bole_pkg::KIND_W-1:0]         in_kind = bole_pkg::KIND_SEARCH;
  logic signed [bole_pkg::KEY_W-1:0]   in_key = '0;
  logic [bole_pkg::VAL_W-1:0]          in_value = '0;
  logic                                out_valid;
  logic [bole_pkg::STAT_W-1:0]         out_status;
  logic signed [bole_pkg::KEY_W-1:0]   out_key;
  logic [bole_pkg::VAL_W-1:0]          out_value;
  logic [COUNT_W-1:0]                  out_entry_count;

  list_scoreboard sb = new();
  int quiet_cycles = 0;
  int fill_bias;

  bounded_ordered_list_engine_core #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_key(in_key),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_key(out_key),
    .out_value(out_value),
    .out_entry_count(out_entry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_command(in_kind, in_key, in_value);
      if (out_valid) sb.check_result(out_status, out_key, out_value, out_entry_count);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic begin_slot(input int idle_pct);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic present(input logic [bole_pkg::KIND_W-1:0] kind,
                         input logic signed [bole_pkg::KEY_W-1:0] key,
                         input logic [bole_pkg::VAL_W-1:0] value);
    in_kind <= kind;
    in_key <= key;
    in_value <= value;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic do_op(input logic [bole_pkg::KIND_W-1:0] kind,
                       input logic signed [bole_pkg::KEY_W-1:0] key,
                       input logic [bole_pkg::VAL_W-1:0] value);
    begin_slot(0);
    present(kind, key, value);
  endtask

  function automatic logic signed [bole_pkg::KEY_W-1:0] choose_key(input bit lookup);
    int pick;
    pick = $urandom_range(9);
    if (lookup && sb.held > 0 && $urandom_range(9) < 7) return sb.held_key();
    if (pick < 5) return bole_pkg::KEY_W'(int'($urandom_range(16)) - 8);
    if (pick == 5) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_phase(input int count, input int idle_pct);
    logic [bole_pkg::KIND_W-1:0] kind;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: fill_bias = 80;
          1: fill_bias = 20;
          default: fill_bias = 50;
        endcase
      end
      begin_slot(idle_pct);
      if ($urandom_range(99) < fill_bias) kind = bole_pkg::KIND_W'($urandom_range(3));
      else kind = bole_pkg::KIND_W'($urandom_range(7, 4));
      present(kind, choose_key(kind >= bole_pkg::KIND_EXT_HEAD || $urandom_range(3) == 0),
              bole_pkg::VAL_W'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do_op(bole_pkg::KIND_EXT_HEAD, 0, 8'h00);
    do_op(bole_pkg::KIND_EXT_TAIL, 0, 8'h00);
    do_op(bole_pkg::KIND_EXT_KEY, 5, 8'h00);
    do_op(bole_pkg::KIND_SEARCH, 5, 8'h00);
    do_op(bole_pkg::KIND_INS_ASC, 0, 8'h5a);
    do_op(bole_pkg::KIND_INS_HEAD, 32'h7fff_ffff, 8'hff);
    do_op(bole_pkg::KIND_INS_TAIL, 32'h8000_0000, 8'h00);
    do_op(bole_pkg::KIND_INS_ASC, -1, 8'h11);
    do_op(bole_pkg::KIND_INS_DESC, 1, 8'h22);
    do_op(bole_pkg::KIND_INS_ASC, -1, 8'h33);
    do_op(bole_pkg::KIND_INS_DESC, 1, 8'h44);
    do_op(bole_pkg::KIND_SEARCH, -1, 8'h00);
    do_op(bole_pkg::KIND_SEARCH, 32'h7fff_ffff, 8'h00);
    do_op(bole_pkg::KIND_SEARCH, 12345, 8'h00);
    do_op(bole_pkg::KIND_EXT_KEY, 32'h8000_0000, 8'h00);
    do_op(bole_pkg::KIND_EXT_KEY, 777, 8'h00);
    do_op(bole_pkg::KIND_EXT_TAIL, 0, 8'h00);
    do_op(bole_pkg::KIND_EXT_HEAD, 0, 8'h00);
    repeat (4) do_op(bole_pkg::KIND_EXT_HEAD, 0, 8'h00);
    do_op(bole_pkg::KIND_INS_DESC, 42, 8'haa);
    do_op(bole_pkg::KIND_EXT_KEY, 42, 8'h00);
    do_op(bole_pkg::KIND_INS_HEAD, -42, 8'h55);
    do_op(bole_pkg::KIND_EXT_TAIL, 0, 8'h00);

    run_phase(534, 15);
    run_phase(533, 46);
    run_phase(533, 0);

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d transactions: %0d ok, %0d empty, %0d full, %0d key not found.",
             sb.checked, sb.status_seen[bole_pkg::STAT_OK],
             sb.status_seen[bole_pkg::STAT_EMPTY], sb.status_seen[bole_pkg::STAT_FULL],
             sb.status_seen[bole_pkg::STAT_NOT_FOUND]);
    $display("Peak list occupancy was %0d of %0d entries.", sb.peak, LIST_DEPTH);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
